// ===== src/filtered_nearest_point_search_top_macros.svh =====
// assertion macros used by the port-level checker
`ifndef FILTERED_NEAREST_POINT_SEARCH_TOP_MACROS_SVH
`define FILTERED_NEAREST_POINT_SEARCH_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FNPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fnps check failed");

// next-cycle implication, sampled on clk, off during reset
`define FNPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fnps check failed");

`endif

// ===== src/fnps_pkg.sv =====
// shared types and constants for the filtered nearest point search block
package fnps_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } ctrl_state_t;

  // one table slot, 51 bits
  typedef struct packed {
    logic [3:0]  kind;
    logic        active;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] band_top;
    logic [9:0]  band_height;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // query beat accepted: latch point and filters, reset best
    logic wr;     // write beat accepted
    logic clr;    // clearing pass: write zeros at the scan address
    logic rd;     // scan read at the scan address
    logic fin;    // scan drained: publish the result
  } cmd_t;

endpackage

// ===== src/fnps_ctrl.sv =====
// controller: clearing pass, scan sequencing and handshake
module fnps_ctrl import fnps_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          mode,
  input  logic          pipe_busy,
  output logic          busy,
  output cmd_t          cmd,
  output logic [AW-1:0] addr
);

  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  ctrl_state_t   state, state_next;
  logic [AW-1:0] addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    busy       = 1'b1;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (addr == LAST) begin
          state_next = ST_IDLE;
          addr_next  = '0;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode) begin
            cmd.load   = 1'b1;
            state_next = ST_SCAN;
            addr_next  = '0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (addr == LAST) begin
          state_next = ST_DRAIN;
          addr_next  = '0;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last read to be folded into the running minimum
        if (!pipe_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/fnps_datapath.sv =====
// datapath: object table, filter and distance pipeline, running minimum
module fnps_datapath import fnps_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [AW-1:0]      addr,
  input  logic [5:0]         slot,
  input  logic [3:0]         kind,
  input  logic               any_kind,
  input  logic               active,
  input  logic signed [11:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [11:0] band_top,
  input  logic [9:0]         band_height,
  input  logic               frontal,
  input  logic               horizontal,
  input  logic signed [10:0] reach,
  output logic               pipe_busy,
  output logic               done,
  output logic               found,
  output logic [5:0]         best_slot,
  output logic [24:0]        dist_sq
);

  localparam int SW = (AW > 6) ? AW : 6;

  // query registers
  logic [3:0]         q_kind;
  logic               q_any, q_front, q_horiz;
  logic signed [12:0] q_px, q_py, q_lo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_kind  <= kind;
      q_any   <= any_kind;
      q_front <= frontal;
      q_horiz <= horizontal;
      q_px    <= {pos_x[11], pos_x};
      q_py    <= {pos_y[11], pos_y};
      q_lo    <= {pos_y[11], pos_y} + {{2{reach[10]}}, reach};
    end
  end

  // table memory
  entry_t        mem [TABLE_DEPTH];
  entry_t        wdata, rd_data;
  logic [SW-1:0] slot_w;
  logic [AW-1:0] waddr;
  logic          slot_ok, we;

  assign slot_w  = SW'(slot);
  assign slot_ok = ({26'd0, slot} < 32'(TABLE_DEPTH));
  assign we      = cmd.clr | (cmd.wr & slot_ok);
  assign waddr   = cmd.clr ? addr : slot_w[AW-1:0];

  always_comb begin
    wdata = '0;
    if (!cmd.clr) begin
      wdata.kind        = kind;
      wdata.active      = active;
      wdata.x           = pos_x;
      wdata.y           = pos_y;
      wdata.band_top    = band_top;
      wdata.band_height = band_height;
    end
  end

  logic [AW-1:0] idx1, idx2, idx3;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[addr];
      idx1    <= addr;
    end
  end

  // stage 2: filters and differences
  logic signed [12:0] ex, ey, etop, ebot, dx_c, dy_c;
  logic               pass_c;
  logic signed [12:0] dx2, dy2;

  always_comb begin
    ex     = {rd_data.x[11], rd_data.x};
    ey     = {rd_data.y[11], rd_data.y};
    etop   = {rd_data.band_top[11], rd_data.band_top};
    ebot   = etop + {3'b000, rd_data.band_height};
    dx_c   = q_px - ex;
    dy_c   = q_py - ey;
    pass_c = rd_data.active
           && (q_any || (rd_data.kind == q_kind))
           && !(q_front && (ex < q_px))
           && !(q_horiz && ((q_lo < etop) || (q_py > ebot)));
  end

  // stage 3: squares
  logic signed [25:0] prod_x, prod_y;
  logic [23:0]        sq_x3, sq_y3;

  assign prod_x = dx2 * dx2;
  assign prod_y = dy2 * dy2;

  always_ff @(posedge clk) begin
    dx2   <= dx_c;
    dy2   <= dy_c;
    idx2  <= idx1;
    sq_x3 <= prod_x[23:0];
    sq_y3 <= prod_y[23:0];
    idx3  <= idx2;
  end

  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1 & pass_c;
      v3 <= v2;
    end
  end

  assign pipe_busy = v1 | v2 | v3;

  // stage 4: running minimum, strict compare keeps the lowest slot on ties
  logic [24:0]   sum3, best_d;
  logic [AW-1:0] best_idx;
  logic [SW-1:0] best_w;
  logic          have;

  assign sum3   = {1'b0, sq_x3} + {1'b0, sq_y3};
  assign best_w = SW'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.load) begin
      have <= 1'b0;
    end else if (v3 && (!have || (sum3 < best_d))) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!have || (sum3 < best_d))) begin
      best_d   <= sum3;
      best_idx <= idx3;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.wr | cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      found     <= 1'b0;
      best_slot <= '0;
      dist_sq   <= '0;
    end else if (cmd.fin) begin
      found     <= have;
      best_slot <= have ? best_w[5:0] : 6'd0;
      dist_sq   <= have ? best_d : 25'd0;
    end
  end

endmodule

// ===== src/filtered_nearest_point_search_top.sv =====
// top level: nearest matching object over a table, one slot read per cycle
// write beat: result strobe in the cycle after accept, next beat accepted at once
// query beat: a scan over every slot, then a read/filter/square/min drain that ends early
//   when the last slots miss the filters, then the result strobe
// reset: a clearing pass writes every slot to zero, with busy high
// results are single-cycle strobes; the receiver cannot stall
module filtered_nearest_point_search_top import fnps_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [5:0]         slot,
  input  logic [3:0]         kind,
  input  logic               any_kind,
  input  logic               active,
  input  logic signed [11:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [11:0] band_top,
  input  logic [9:0]         band_height,
  input  logic               frontal,
  input  logic               horizontal,
  input  logic signed [10:0] reach,
  output logic               done,
  output logic               found,
  output logic [5:0]         best_slot,
  output logic [24:0]        dist_sq
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cmd_t          cmd;
  logic [AW-1:0] addr;
  logic          pipe_busy;

  fnps_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  fnps_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr        (addr),
    .slot        (slot),
    .kind        (kind),
    .any_kind    (any_kind),
    .active      (active),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .band_top    (band_top),
    .band_height (band_height),
    .frontal     (frontal),
    .horizontal  (horizontal),
    .reach       (reach),
    .pipe_busy   (pipe_busy),
    .done        (done),
    .found       (found),
    .best_slot   (best_slot),
    .dist_sq     (dist_sq)
  );

endmodule

// ===== src/fnps_checker.sv =====
// port-level checker for the filtered nearest point search top, with its bind
`include "filtered_nearest_point_search_top_macros.svh"

module fnps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        mode,
  input logic        done,
  input logic        found,
  input logic [5:0]  best_slot,
  input logic [24:0] dist_sq
);

  // a write beat is answered in the next cycle with an all-zero result
  `FNPS_ASSERT_NEXT(a_write_result, start && !busy && !mode, done && !found && best_slot == 6'd0 && dist_sq == 25'd0)

  // a query beat makes the block busy, with no result shown yet
  `FNPS_ASSERT_NEXT(a_query_busy, start && !busy && mode, busy && !done)

  // the block is idle whenever a result is shown
  `FNPS_ASSERT_NOW(a_done_idle, done, !busy)

  // a miss carries zero slot and distance
  `FNPS_ASSERT_NOW(a_miss_zero, done && !found, best_slot == 6'd0 && dist_sq == 25'd0)

endmodule

bind filtered_nearest_point_search_top fnps_checker u_fnps_checker (.*);

// ===== dv/filtered_nearest_point_search_top_tb.sv =====
// testbench for the filtered nearest point search top: directed and random beats, checked in order
`timescale 1ns / 100ps

module filtered_nearest_point_search_top_tb;
  import fnps_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_BEATS   = 1700;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;

  typedef struct {
    logic               mode;
    logic [5:0]         slot;
    logic [3:0]         kind;
    logic               any_kind;
    logic               active;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] band_top;
    logic [9:0]         band_height;
    logic               frontal;
    logic               horizontal;
    logic signed [10:0] reach;
  } beat_t;

  typedef struct {
    logic        found;
    logic [5:0]  best_slot;
    logic [24:0] dist_sq;
  } nearest_t;

  typedef struct {
    logic [3:0] kind;
    logic       active;
    int         x;
    int         y;
    int         band_top;
    int         band_height;
  } object_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               mode = 1'b0;
  logic [5:0]         slot = '0;
  logic [3:0]         kind = '0;
  logic               any_kind = 1'b0;
  logic               active = 1'b0;
  logic signed [11:0] pos_x = '0;
  logic signed [11:0] pos_y = '0;
  logic signed [11:0] band_top = '0;
  logic [9:0]         band_height = '0;
  logic               frontal = 1'b0;
  logic               horizontal = 1'b0;
  logic signed [10:0] reach = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [5:0]         best_slot;
  logic [24:0]        dist_sq;

  object_t  object_shadow [DEPTH];
  nearest_t pending_results [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       no_gaps = 1'b0;

  filtered_nearest_point_search_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .slot(slot), .kind(kind), .any_kind(any_kind), .active(active),
    .pos_x(pos_x), .pos_y(pos_y), .band_top(band_top), .band_height(band_height),
    .frontal(frontal), .horizontal(horizontal), .reach(reach),
    .done(done), .found(found), .best_slot(best_slot), .dist_sq(dist_sq)
  );

  always #1 clk = ~clk;

  // updates the shadow table on a write, scans it on a query
  function automatic nearest_t nearest_match(input beat_t b);
    nearest_t r;
    int px, py, dx, dy;
    longint d;
    r.found = 1'b0;
    r.best_slot = '0;
    r.dist_sq = '0;
    px = int'(b.pos_x);
    py = int'(b.pos_y);
    if (b.mode == MODE_WRITE) begin
      object_shadow[b.slot].kind = b.kind;
      object_shadow[b.slot].active = b.active;
      object_shadow[b.slot].x = px;
      object_shadow[b.slot].y = py;
      object_shadow[b.slot].band_top = int'(b.band_top);
      object_shadow[b.slot].band_height = int'(b.band_height);
      return r;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (!object_shadow[i].active) continue;
      if (!b.any_kind && object_shadow[i].kind != b.kind) continue;
      if (b.frontal && object_shadow[i].x < px) continue;
      if (b.horizontal) begin
        if (py + int'(b.reach) < object_shadow[i].band_top) continue;
        if (py > object_shadow[i].band_top + object_shadow[i].band_height) continue;
      end
      dx = px - object_shadow[i].x;
      dy = py - object_shadow[i].y;
      d = longint'(dx) * dx + longint'(dy) * dy;
      // strict less keeps the lowest slot on a tie
      if (!r.found || d < r.dist_sq) begin
        r.found = 1'b1;
        r.best_slot = i[5:0];
        r.dist_sq = d[24:0];
      end
    end
    return r;
  endfunction

  // result check and prediction on every edge
  always @(posedge clk) begin
    nearest_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result strobe with no result pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            mismatches++;
          end
          if (best_slot !== want.best_slot) begin
            $error("best_slot: expected %0d, actual %0d", want.best_slot, best_slot);
            mismatches++;
          end
          if (dist_sq !== want.dist_sq) begin
            $error("dist_sq: expected %0d, actual %0d", want.dist_sq, dist_sq);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.insert(pending_results.size(),
            nearest_match('{mode, slot, kind, any_kind, active,
            pos_x, pos_y, band_top, band_height, frontal, horizontal, reach}));
      end
    end
    if (done || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("filtered_nearest_point_search_top test failed");
    $finish;
  end

  // returns right after the edge that accepted the beat, start still high
  task automatic send_beat(input beat_t b);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= b.mode;
    slot        <= b.slot;
    kind        <= b.kind;
    any_kind    <= b.any_kind;
    active      <= b.active;
    pos_x       <= b.pos_x;
    pos_y       <= b.pos_y;
    band_top    <= b.band_top;
    band_height <= b.band_height;
    frontal     <= b.frontal;
    horizontal  <= b.horizontal;
    reach       <= b.reach;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_object(input int s, input int k, input bit act, input int x, input int y,
                            input int top, input int h);
    beat_t b;
    b = '{MODE_WRITE, 6'(s), 4'(k), 1'b0, act, 12'(x), 12'(y), 12'(top), 10'(h),
          1'b0, 1'b0, '0};
    send_beat(b);
  endtask

  task automatic run_query(input int k, input bit any, input int x, input int y,
                           input bit fr, input bit hz, input int r);
    beat_t b;
    b = '{MODE_QUERY, '0, 4'(k), any, 1'b0, 12'(x), 12'(y), '0, '0, fr, hz, 11'(r)};
    send_beat(b);
  endtask

  task automatic test_empty_table;
    run_query(0, 1'b1, 0, 0, 1'b0, 1'b0, 0);
  endtask

  task automatic test_extremes;
    put_object(0, 15, 1'b1, -2048, -2048, -2048, 1023);
    put_object(63, 0, 1'b1, 2047, 2047, 2047, 0);
    run_query(0, 1'b1, 2047, 2047, 1'b0, 1'b0, 0);
    // farthest pair gives the largest distance
    run_query(15, 1'b0, 2047, 2047, 1'b0, 1'b0, 0);
  endtask

  task automatic test_kind_filter;
    run_query(0, 1'b0, -2048, -2048, 1'b0, 1'b0, 0);
    run_query(5, 1'b0, 0, 0, 1'b0, 1'b0, 0);
  endtask

  task automatic test_band_filter;
    put_object(10, 3, 1'b1, 0, 0, 100, 50);
    run_query(0, 1'b1, 0, 0, 1'b0, 1'b1, 1023);
    // upward range misses every band
    run_query(0, 1'b1, 0, 0, 1'b0, 1'b1, -1024);
    run_query(0, 1'b1, 0, 150, 1'b0, 1'b1, 0);
  endtask

  task automatic test_frontal_filter;
    run_query(0, 1'b1, 1, 0, 1'b1, 1'b0, 0);
  endtask

  task automatic test_ties_and_inactive;
    put_object(20, 7, 1'b1, 10, 0, 0, 0);
    put_object(21, 7, 1'b1, -10, 0, 0, 0);
    put_object(5, 7, 1'b0, 0, 0, 0, 0);
    run_query(7, 1'b0, 0, 0, 1'b0, 1'b0, 0);
    put_object(20, 7, 1'b0, 10, 0, 0, 0);
    run_query(7, 1'b0, 0, 0, 1'b0, 1'b0, 0);
  endtask

  function automatic logic signed [11:0] pick_coord(input bit tight);
    return tight ? 12'($urandom_range(0, 16) - 8) : 12'($urandom_range(0, 4095));
  endfunction

  task automatic test_random_traffic;
    beat_t b;
    bit tight;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      no_gaps = (n >= 700 && n < 1000);
      tight = ($urandom_range(0, 2) == 0);
      b.mode = ($urandom_range(0, 99) < 55) ? MODE_WRITE : MODE_QUERY;
      b.slot = 6'($urandom_range(0, 63));
      b.kind = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      b.any_kind = 1'($urandom_range(0, 1));
      b.active = ($urandom_range(0, 99) < 80);
      b.pos_x = pick_coord(tight);
      b.pos_y = pick_coord(tight);
      b.band_top = $urandom_range(0, 1) ? pick_coord(1'b0) : 12'(b.pos_y - $urandom_range(0, 64));
      b.band_height = 10'($urandom_range(0, 1023));
      b.frontal = 1'($urandom_range(0, 1));
      b.horizontal = 1'($urandom_range(0, 1));
      b.reach = ($urandom_range(0, 99) < 70) ? 11'($urandom_range(0, 300))
                                              : 11'($urandom_range(0, 2047));
      send_beat(b);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DEPTH; i++) object_shadow[i] = '{4'd0, 1'b0, 0, 0, 0, 0};
    test_empty_table();
    test_extremes();
    test_kind_filter();
    test_band_filter();
    test_frontal_filter();
    test_ties_and_inactive();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("filtered_nearest_point_search_top test passed");
    end else begin
      $display("filtered_nearest_point_search_top test failed");
    end
    $finish;
  end

endmodule
